// ===== rtl/frn_pkg.sv =====
`default_nettype none

package frn_pkg;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_GCD  = 5'b00010,
    S_QNUM = 5'b00100,
    S_QDEN = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/frn_div.sv =====
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module frn_div #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DATA_WIDTH-1:0] dividend,
  input  wire logic [DATA_WIDTH-1:0] divisor,
  output logic                       done,
  output logic [DATA_WIDTH-1:0]      quot,
  output logic [DATA_WIDTH-1:0]      rem
);

  localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  logic                  busy;
  logic [CW-1:0]         cnt;
  logic [DATA_WIDTH-1:0] dvs;
  logic [DATA_WIDTH:0]   trial;

  // Trial subtract of the divisor from the shifted partial remainder
  assign trial = {rem, quot[DATA_WIDTH-1]} - {1'b0, dvs};

  // Load on start, then shift one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DATA_WIDTH - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient share one shift path
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      if (!trial[DATA_WIDTH]) begin
        rem  <= trial[DATA_WIDTH-1:0];
        quot <= {quot[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem  <= {rem[DATA_WIDTH-2:0], quot[DATA_WIDTH-1]};
        quot <= {quot[DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fraction_normalize_reduce.sv =====
`default_nettype none

// Fraction normalizer: takes a signed num_in/den_in word and returns the same fraction
// reduced to lowest terms, with the sign on num_out and den_out at least 1. A reduced
// magnitude too wide for DATA_WIDTH-1 bits saturates. A zero denominator counts as 1
// and a zero numerator gives 0/1 without a division. Otherwise the gcd of the
// magnitudes is found with Euclid's remainder loop, and both magnitudes are divided by
// it, all on one shared restoring divider. One word is in flight at a time: in_ready
// is high only while the block is idle.
module fraction_normalize_reduce import frn_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [DATA_WIDTH-1:0] num_in,
  input  wire logic signed [DATA_WIDTH-1:0] den_in,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      num_out,
  output logic [DATA_WIDTH-2:0]             den_out
);

  state_t                state;
  logic [DATA_WIDTH-1:0] nm;
  logic [DATA_WIDTH-1:0] dm;
  logic                  neg;
  logic [DATA_WIDTH-1:0] gcd_b;
  logic [DATA_WIDTH-1:0] op_a;
  logic [DATA_WIDTH-1:0] op_b;
  logic                  div_start;
  logic [DATA_WIDTH-2:0] num_sat;

  logic                  div_done;
  logic [DATA_WIDTH-1:0] div_quot;
  logic [DATA_WIDTH-1:0] div_rem;

  logic                  num_neg;
  logic                  den_neg;
  logic [DATA_WIDTH-1:0] num_mag;
  logic [DATA_WIDTH-1:0] den_mag;
  logic [DATA_WIDTH-1:0] num_res;

  // Sign and magnitude of the incoming word
  always_comb begin
    num_neg = num_in[DATA_WIDTH-1];
    den_neg = den_in[DATA_WIDTH-1];
    num_mag = num_neg ? (~num_in + 1'b1) : num_in;
    den_mag = den_neg ? (~den_in + 1'b1) : den_in;
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // Apply the sign to the saturated numerator magnitude
  assign num_res = neg ? (~{1'b0, num_sat} + 1'b1) : {1'b0, num_sat};

  frn_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (op_a),
    .divisor  (op_b),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (num_mag == '0) begin
              state <= S_OUT;
            end else begin
              state     <= S_GCD;
              div_start <= 1'b1;
            end
          end
        end
        S_GCD: begin
          if (div_done) begin
            div_start <= 1'b1;
            if (div_rem == '0) begin
              state <= S_QNUM;
            end
          end
        end
        S_QNUM: begin
          if (div_done) begin
            state     <= S_QDEN;
            div_start <= 1'b1;
          end
        end
        S_QDEN: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Operands, gcd tracking and result words
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          nm    <= num_mag;
          dm    <= (den_mag == '0) ? DATA_WIDTH'(1) : den_mag;
          neg   <= num_neg ^ (den_neg && den_mag != '0);
          op_a  <= num_mag;
          op_b  <= (den_mag == '0) ? DATA_WIDTH'(1) : den_mag;
          gcd_b <= (den_mag == '0) ? DATA_WIDTH'(1) : den_mag;
          if (num_mag == '0) begin
            num_out <= '0;
            den_out <= (DATA_WIDTH-1)'(1);
          end
        end
      end
      S_GCD: begin
        if (div_done) begin
          if (div_rem == '0) begin
            op_a <= nm;
            op_b <= gcd_b;
          end else begin
            op_a  <= gcd_b;
            op_b  <= div_rem;
            gcd_b <= div_rem;
          end
        end
      end
      S_QNUM: begin
        if (div_done) begin
          num_sat <= div_quot[DATA_WIDTH-1] ? '1 : div_quot[DATA_WIDTH-2:0];
          op_a    <= dm;
          op_b    <= gcd_b;
        end
      end
      S_QDEN: begin
        if (div_done) begin
          num_out <= num_res;
          den_out <= div_quot[DATA_WIDTH-1] ? '1 : div_quot[DATA_WIDTH-2:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/frn_checker.sv =====
`default_nettype none

// Port-level checks for the fraction normalizer
module frn_checker #(
  parameter int DATA_WIDTH = 32
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic signed [DATA_WIDTH-1:0] num_out,
  input wire logic [DATA_WIDTH-2:0]        den_out
);

  // Denominator of a shown word is never zero
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> den_out != '0)
    else $error("den_out is zero");

  // Zero numerator always comes out as 0/1
  a_zero_canon: assert property (@(posedge clk) disable iff (rst)
    (out_valid && num_out == '0) |-> den_out == (DATA_WIDTH-1)'(1))
    else $error("zero result not 0/1");

  // Accepting a word makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after accept");

  // Never idle and holding a result at once
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid both high");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(num_out) && $stable(den_out)))
    else $error("stalled result changed");

endmodule

bind fraction_normalize_reduce frn_checker #(.DATA_WIDTH(DATA_WIDTH)) u_frn_checker (.*);

`default_nettype wire
